// File: design/ccc_pkg.sv
// shared types, constants and the srgb linearization table for the contrast checker
package ccc_pkg;

  // channel and table geometry
  localparam int CHAN_W      = 8;
  localparam int TABLE_DEPTH = 2 ** CHAN_W;
  localparam int TABLE_BITS  = 30;
  localparam int LIN_W       = TABLE_BITS + 1;
  localparam int RND_W       = LIN_W + 1;

  // luminance weights, scaled by ten thousand
  localparam int W_RED   = 2126;
  localparam int W_GREEN = 7152;
  localparam int W_BLUE  = 722;
  localparam int LUM_DEN = 10000;
  localparam int PROD_W  = 43;
  localparam int SUM_W   = 44;

  // constant divider geometry: one radix-16 digit per stage
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = SUM_W / DIGIT_W;
  localparam int REM_W     = 14;

  // pipeline depth of each part
  localparam int LUMA_STAGES  = 3;
  localparam int JUDGE_STAGES = 3;

  // contrast threshold, 0.33333 as a ratio of integers
  localparam int RATIO_NUM   = 100000;
  localparam int RATIO_DEN   = 33333;
  localparam int RATIO_NUM_W = 17;

  // reference colors: black, white and #BBBBBB, all gray
  localparam int NUM_REFS = 3;
  localparam logic [NUM_REFS-1:0][CHAN_W-1:0] REF_CHAN = {8'hBB, 8'hFF, 8'h00};

  // srgb curve constants in integer form
  localparam int LOW_LIMIT = 10;
  localparam int LOW_SCALE = 100;
  localparam longint LOW_DEN = 329460;
  localparam int CURVE_SCALE = 1000;
  localparam int CURVE_OFS = 14025;
  localparam int CURVE_DEN = 269025;
  localparam int CURVE_POW = 12;
  localparam int CURVE_ROOT = 5;
  localparam int BIG_W = 400;

  typedef logic [TABLE_DEPTH-1:0][LIN_W-1:0] lin_tab_t;

  // one table entry: floor(lin(c) * 2^30), exact
  // upper segment: largest z with z^5 * den^12 <= a^12 * 2^150
  function automatic logic [LIN_W-1:0] lin_entry(input int c);
    logic [BIG_W-1:0] a_big;
    logic [BIG_W-1:0] b_pow;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] mid_pow;
    logic [LIN_W-1:0] lo;
    logic [LIN_W-1:0] hi;
    logic [LIN_W-1:0] mid;
    logic [63:0] low_val;
    if (c <= LOW_LIMIT) begin
      low_val = (64'(c * LOW_SCALE) << TABLE_BITS) / LOW_DEN;
      return LIN_W'(low_val);
    end
    a_big = BIG_W'(c * CURVE_SCALE + CURVE_OFS);
    b_pow = BIG_W'(1);
    rhs   = BIG_W'(1);
    for (int k = 0; k < CURVE_POW; k++) begin
      b_pow = b_pow * BIG_W'(CURVE_DEN);
      rhs   = rhs * a_big;
    end
    rhs = rhs << (CURVE_ROOT * TABLE_BITS);
    lo  = '0;
    hi  = LIN_W'(1) << TABLE_BITS;
    for (int it = 0; it < LIN_W; it++) begin
      if (lo < hi) begin
        mid     = lo + ((hi - lo + LIN_W'(1)) >> 1);
        mid_pow = BIG_W'(mid);
        for (int k = 1; k < CURVE_ROOT; k++) begin
          mid_pow = mid_pow * BIG_W'(mid);
        end
        lhs = b_pow * mid_pow;
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - LIN_W'(1);
        end
      end
    end
    return lo;
  endfunction

  function automatic lin_tab_t build_lin_table();
    lin_tab_t t;
    for (int c = 0; c < TABLE_DEPTH; c++) begin
      t[c] = lin_entry(c);
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

  // q0.30 luminance of a reference gray; weights sum to the divisor
  function automatic logic [LIN_W-1:0] ref_l30(input int idx);
    logic [SUM_W-1:0] s;
    s = SUM_W'(LIN_TABLE[REF_CHAN[idx]]) * SUM_W'(W_RED + W_GREEN + W_BLUE);
    return LIN_W'(s / LUM_DEN);
  endfunction

  // round half up from q0.30 to q0.fb
  function automatic logic [RND_W-1:0] round_lum(input int fb, input logic [LIN_W-1:0] l30);
    return (RND_W'(l30) + (RND_W'(1) << (TABLE_BITS - fb - 1))) >> (TABLE_BITS - fb);
  endfunction

endpackage

// File: design/ccc_ifs.sv
// stream interfaces for the color beat and the result beat
interface ccc_pixel_if;
  import ccc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
  modport monitor (input valid, ready, red, green, blue);
endinterface

interface ccc_result_if;
  logic        valid;
  logic        ready;
  logic        passes;
  logic [15:0] rel_luminance;

  modport source (output valid, passes, rel_luminance, input ready);
  modport sink (input valid, passes, rel_luminance, output ready);
  modport monitor (input valid, ready, passes, rel_luminance);
endinterface

// File: design/ccc_luma.sv
// table lookup, channel weighting and weighted sum, three stages
module ccc_luma (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ccc_pkg::CHAN_W-1:0]   red,
  input  logic [ccc_pkg::CHAN_W-1:0]   green,
  input  logic [ccc_pkg::CHAN_W-1:0]   blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ccc_pkg::SUM_W-1:0]    sum
);
  import ccc_pkg::*;

  logic              v_lin;
  logic              v_prod;
  logic              v_sum;
  logic              rdy_lin;
  logic              rdy_prod;
  logic              rdy_sum;
  logic [LIN_W-1:0]  lin_r;
  logic [LIN_W-1:0]  lin_g;
  logic [LIN_W-1:0]  lin_b;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;

  // per-stage backpressure, bubbles collapse
  assign rdy_sum  = !v_sum || out_ready;
  assign rdy_prod = !v_prod || rdy_sum;
  assign rdy_lin  = !v_lin || rdy_prod;
  assign in_ready = rdy_lin;
  assign out_valid = v_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_lin  <= 1'b0;
      v_prod <= 1'b0;
      v_sum  <= 1'b0;
    end else begin
      if (rdy_lin) begin
        v_lin <= in_valid;
      end
      if (rdy_prod) begin
        v_prod <= v_lin;
      end
      if (rdy_sum) begin
        v_sum <= v_prod;
      end
    end
    // linearize each channel
    if (rdy_lin && in_valid) begin
      lin_r <= LIN_TABLE[red];
      lin_g <= LIN_TABLE[green];
      lin_b <= LIN_TABLE[blue];
    end
    // weight each channel
    if (rdy_prod && v_lin) begin
      prod_r <= PROD_W'(lin_r) * PROD_W'(W_RED);
      prod_g <= PROD_W'(lin_g) * PROD_W'(W_GREEN);
      prod_b <= PROD_W'(lin_b) * PROD_W'(W_BLUE);
    end
    // add the weighted channels
    if (rdy_sum && v_prod) begin
      sum <= SUM_W'(prod_r) + SUM_W'(prod_g) + SUM_W'(prod_b);
    end
  end

endmodule

// File: design/ccc_div.sv
// pipelined radix-16 division of the weighted sum by ten thousand
module ccc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ccc_pkg::SUM_W-1:0]   dividend,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ccc_pkg::LIN_W-1:0]   quotient
);
  import ccc_pkg::*;

  localparam int X_W = REM_W + DIGIT_W;

  logic [DIV_STEPS-1:0]            v;
  logic [DIV_STEPS:0]              rdy;
  logic [DIV_STEPS-1:0][REM_W-1:0] rem;
  logic [DIV_STEPS-1:0][SUM_W-1:0] work;

  assign rdy[DIV_STEPS] = out_ready;
  assign in_ready       = rdy[0];
  assign out_valid      = v[DIV_STEPS-1];
  assign quotient       = work[DIV_STEPS-1][LIN_W-1:0];

  // work holds unused dividend digits on top and quotient digits below
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic               step_valid;
    logic [REM_W-1:0]   rem_in;
    logic [SUM_W-1:0]   work_in;
    logic [X_W-1:0]     x;
    logic [DIGIT_W-1:0] digit;

    if (j == 0) begin : g_first
      assign step_valid = in_valid;
      assign rem_in     = '0;
      assign work_in    = dividend;
    end else begin : g_next
      assign step_valid = v[j-1];
      assign rem_in     = rem[j-1];
      assign work_in    = work[j-1];
    end

    assign rdy[j] = !v[j] || rdy[j+1];
    assign x      = {rem_in, work_in[SUM_W-1 -: DIGIT_W]};

    // quotient digit: the largest multiple of the divisor that fits
    always_comb begin
      digit = '0;
      for (int k = 1; k < 2 ** DIGIT_W; k++) begin
        if (x >= X_W'(k * LUM_DEN)) begin
          digit = DIGIT_W'(k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= step_valid;
      end
      if (rdy[j] && step_valid) begin
        rem[j]  <= REM_W'(x - X_W'(int'(digit) * LUM_DEN));
        work[j] <= {work_in[SUM_W-DIGIT_W-1:0], digit};
      end
    end
  end

endmodule

// File: design/ccc_judge.sv
// rounding, contrast ratios against the references and the output register
module ccc_judge #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ccc_pkg::LIN_W-1:0]   l30,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        passes,
  output logic [15:0]                 rel_luminance
);
  import ccc_pkg::*;

  localparam int NUM_W = FRACTION_BITS + 1;
  localparam int PRD_W = NUM_W + RATIO_NUM_W;
  localparam int E_INT = (2 ** FRACTION_BITS + 10) / 20;
  localparam logic [NUM_W-1:0] E = NUM_W'(E_INT);

  logic                            v_rnd;
  logic                            v_ratio;
  logic                            v_out;
  logic                            rdy_rnd;
  logic                            rdy_ratio;
  logic                            rdy_out;
  logic [NUM_W-1:0]                lum;
  logic [16:0]                     lum17;
  logic [15:0]                     lum16;
  logic [15:0]                     lum16_q;
  logic [NUM_REFS-1:0][NUM_W-1:0]  num;
  logic [NUM_REFS-1:0][NUM_W-1:0]  den;
  logic [NUM_REFS-1:0]             fail;

  assign rdy_out   = !v_out || out_ready;
  assign rdy_ratio = !v_ratio || rdy_out;
  assign rdy_rnd   = !v_rnd || rdy_ratio;
  assign in_ready  = rdy_rnd;
  assign out_valid = v_out;

  // bring q0.fb luminance to q0.16, saturating
  if (FRACTION_BITS >= 16) begin : g_narrow
    assign lum17 = 17'(lum >> (FRACTION_BITS - 16));
  end else begin : g_wide
    assign lum17 = 17'(lum) << (16 - FRACTION_BITS);
  end
  assign lum16 = lum17[16] ? 16'hFFFF : lum17[15:0];

  // one lane per reference: order the pair, then cross-multiply
  for (genvar i = 0; i < NUM_REFS; i++) begin : g_ref
    localparam logic [NUM_W-1:0] REF_LUM = NUM_W'(round_lum(FRACTION_BITS, ref_l30(i)));

    always_ff @(posedge clk) begin
      if (rdy_ratio && v_rnd) begin
        if (REF_LUM > lum) begin
          num[i] <= lum + E;
          den[i] <= REF_LUM + E;
        end else begin
          num[i] <= REF_LUM + E;
          den[i] <= lum + E;
        end
      end
    end

    assign fail[i] = (PRD_W'(num[i]) * PRD_W'(RATIO_NUM)) > (PRD_W'(den[i]) * PRD_W'(RATIO_DEN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_rnd   <= 1'b0;
      v_ratio <= 1'b0;
      v_out   <= 1'b0;
    end else begin
      if (rdy_rnd) begin
        v_rnd <= in_valid;
      end
      if (rdy_ratio) begin
        v_ratio <= v_rnd;
      end
      if (rdy_out) begin
        v_out <= v_ratio;
      end
    end
    // round to the working precision
    if (rdy_rnd && in_valid) begin
      lum <= NUM_W'(round_lum(FRACTION_BITS, l30));
    end
    if (rdy_ratio && v_rnd) begin
      lum16_q <= lum16;
    end
    // result beat
    if (rdy_out && v_ratio) begin
      passes        <= ~|fail;
      rel_luminance <= lum16_q;
    end
  end

endmodule

// File: design/color_contrast_check.sv
// top level of the wcag contrast checker
//
//   channel   dir   beat fields                      notes
//   pixel     in    red, green, blue (8b each)       valid/ready
//   result    out   passes (1b), rel_luminance (16b) valid/ready, registered
//
// one color is accepted every clock while the output is not held; a result passes
// through 3 luminance stages, 11 divider stages and 3 ratio stages
// the divide by ten thousand, one radix-16 digit per stage, sets the depth
// reset clears every valid bit; no payload register is reset
// ready runs back through every stage in the same cycle; a stage holds only
// while the one after it is full and held, so empty slots fill while the
// output waits
module color_contrast_check #(
  parameter int FRACTION_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  ccc_pixel_if.sink    pixel,
  ccc_result_if.source result
);
  import ccc_pkg::*;

  logic             luma_valid;
  logic             luma_ready;
  logic [SUM_W-1:0] luma_sum;
  logic             div_valid;
  logic             div_ready;
  logic [LIN_W-1:0] div_quot;

  // weighted linear sum
  ccc_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .red       (pixel.red),
    .green     (pixel.green),
    .blue      (pixel.blue),
    .out_valid (luma_valid),
    .out_ready (luma_ready),
    .sum       (luma_sum)
  );

  // q0.30 luminance
  ccc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (luma_valid),
    .in_ready  (luma_ready),
    .dividend  (luma_sum),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .quotient  (div_quot)
  );

  // contrast decision and output register
  ccc_judge #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_judge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (div_valid),
    .in_ready      (div_ready),
    .l30           (div_quot),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .passes        (result.passes),
    .rel_luminance (result.rel_luminance)
  );

endmodule

// File: design/ccc_check.sv
// port-level checker for the contrast checker, bound to the top level
module ccc_check (
  input logic          clk,
  input logic          rst,
  ccc_pixel_if.sink    pixel,
  ccc_result_if.source result
);
  import ccc_pkg::*;

  localparam int DEPTH = LUMA_STAGES + DIV_STEPS + JUDGE_STAGES;
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic             in_beat;
  logic             out_beat;
  logic [CNT_W-1:0] inflight;

  assign in_beat  = pixel.valid && pixel.ready;
  assign out_beat = result.valid && result.ready;

  // colors accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_beat) - CNT_W'(out_beat);
    end
  end

  // never more colors inside than pipeline slots
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(DEPTH))
    else $error("more colors in flight than pipeline stages");

  // a result beat always answers an accepted color
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> inflight != '0)
    else $error("result beat with no color in flight");

  // an empty or draining output lets a color in
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!result.valid || result.ready) |-> pixel.ready)
    else $error("input stalled while the output can move");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=>
      (result.valid && $stable(result.passes) && $stable(result.rel_luminance)))
    else $error("stalled result beat changed");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule

bind color_contrast_check ccc_check u_check (
  .clk    (clk),
  .rst    (rst),
  .pixel  (pixel),
  .result (result)
);

// File: bench/tb_top.sv
// testbench for color_contrast_check: own luminance and contrast predictor with scoreboard
`timescale 1ns / 100ps

module tb_top;
  import ccc_pkg::*;

  localparam int FRAC      = 16;
  localparam int BIG       = 400;
  localparam int PHASE_LEN = 270;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  // expected verdicts for accepted colors, checked in order
  class contrast_scoreboard;
    typedef struct {
      logic        passes;
      logic [15:0] lum;
    } verdict_t;

    logic [LIN_W-1:0] lin_curve [TABLE_DEPTH];
    longint unsigned  gray_lum [3];
    logic [BIG-1:0]   den_pow12;
    verdict_t         expected_verdicts [$];
    int               errors;

    function new();
      den_pow12 = BIG'(1);
      for (int k = 0; k < 12; k++) den_pow12 = den_pow12 * BIG'(269025);
      for (int c = 0; c < TABLE_DEPTH; c++) lin_curve[c] = linearize(c);
      gray_lum[0] = luminance(0, 0, 0);
      gray_lum[1] = luminance(255, 255, 255);
      gray_lum[2] = luminance(187, 187, 187);
      errors = 0;
    endfunction

    // z^5 * 269025^12 <= a^12 * 2^150, i.e. z <= lin * 2^30
    function bit root_fits(longint unsigned z, logic [BIG-1:0] num_pow);
      logic [BIG-1:0] zp;
      zp = BIG'(1);
      for (int k = 0; k < 5; k++) zp = zp * BIG'(z);
      return (den_pow12 * zp) <= num_pow;
    endfunction

    // floor(lin(c) * 2^30): float estimate, then exact correction
    function logic [LIN_W-1:0] linearize(int c);
      logic [BIG-1:0]  num_pow;
      longint unsigned z;
      longint unsigned one;
      real             base;
      one = 64'd1 << 30;
      if (c <= 10) return LIN_W'(((64'(c) * 100) << 30) / 329460);
      num_pow = BIG'(1);
      for (int k = 0; k < 12; k++) num_pow = num_pow * BIG'(c * 1000 + 14025);
      num_pow = num_pow << 150;
      base = (c * 1000.0 + 14025.0) / 269025.0;
      z = longint'($pow(base, 2.4) * 1073741824.0);
      if (z > one) z = one;
      while (z < one && root_fits(z + 1, num_pow)) z++;
      while (!root_fits(z, num_pow)) z--;
      return LIN_W'(z);
    endfunction

    // weighted sum in q0.30, then rounded half up to q0.FRAC
    function longint unsigned luminance(int r, int g, int b);
      longint unsigned s;
      longint unsigned l30;
      s = 64'(lin_curve[r]) * 2126 + 64'(lin_curve[g]) * 7152 + 64'(lin_curve[b]) * 722;
      l30 = s / 10000;
      return (l30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    endfunction

    function verdict_t contrast_verdict(color_t c);
      longint unsigned f;
      longint unsigned e;
      longint unsigned num;
      longint unsigned den;
      longint unsigned lum16;
      verdict_t v;
      f = luminance(c.red, c.green, c.blue);
      e = ((64'd1 << FRAC) + 10) / 20;
      v.passes = 1'b1;
      // darker over lighter against each reference gray
      for (int i = 0; i < 3; i++) begin
        num = (gray_lum[i] > f) ? f + e : gray_lum[i] + e;
        den = (gray_lum[i] > f) ? gray_lum[i] + e : f + e;
        if (num * 100000 > den * 33333) v.passes = 1'b0;
      end
      if (FRAC >= 16) lum16 = f >> (FRAC - 16);
      else lum16 = f << (16 - FRAC);
      if (lum16 > 65535) lum16 = 65535;
      v.lum = lum16[15:0];
      return v;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void note_color(color_t c);
      expected_verdicts.push_back(contrast_verdict(c));
    endfunction

    function void check_result(logic passes, logic [15:0] lum);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        flag($sformatf("result beat with nothing expected: passes %0b lum %0d", passes, lum));
        return;
      end
      v = expected_verdicts.pop_front();
      if (v.passes !== passes)
        flag($sformatf("passes mismatch: expected %0b, got %0b", v.passes, passes));
      if (v.lum !== lum)
        flag($sformatf("rel_luminance mismatch: expected %0d, got %0d", v.lum, lum));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;

  contrast_scoreboard board = new();

  ccc_pixel_if  pix_if ();
  ccc_result_if res_if ();

  color_contrast_check #(
    .FRACTION_BITS(FRAC)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix_if),
    .result(res_if)
  );

  // corners, references, low segment edge and the pass band edges
  color_t corner_colors [22] = '{
    24'h000000, 24'hFFFFFF, 24'hBBBBBB, 24'h0A0A0A, 24'h0B0B0B, 24'h010101,
    24'hFEFEFE, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hAA55AA, 24'h55AA55,
    24'h595959, 24'h5A5A5A, 24'h6D6D6D, 24'h6E6E6E, 24'h646464, 24'hBABABA,
    24'hBCBCBC, 24'h808080, 24'h0A000B, 24'hFFFF00
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      board.check_result(res_if.passes, res_if.rel_luminance);
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_color(input color_t c);
    while ($urandom_range(99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= c.red;
    pix_if.green <= c.green;
    pix_if.blue  <= c.blue;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    board.note_color(c);
  endtask

  // hold the sender until every expected result is back
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (board.expected_verdicts.size() != 0) @(posedge clk);
  endtask

  // half fully random, half near-gray colors around the narrow pass band
  function automatic color_t random_color();
    color_t c;
    int     base;
    if ($urandom_range(1)) begin
      c.red   = CHAN_W'($urandom_range(255));
      c.green = CHAN_W'($urandom_range(255));
      c.blue  = CHAN_W'($urandom_range(255));
    end else begin
      base    = $urandom_range(120, 80);
      c.red   = CHAN_W'(base + $urandom_range(16) - 8);
      c.green = CHAN_W'(base + $urandom_range(16) - 8);
      c.blue  = CHAN_W'(base + $urandom_range(16) - 8);
    end
    return c;
  endfunction

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle  = '{0, 69, 0, 22};
    phase_stall = '{0, 0, 69, 22};
    idle_pct  = 0;
    stall_pct = 0;
    rst          <= 1'b1;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed colors back to back
    foreach (corner_colors[i]) send_color(corner_colors[i]);
    drain_results();

    // random colors under each mix of sender idles and receiver stalls
    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < PHASE_LEN; n++) send_color(random_color());
      drain_results();
    end

    // quiet tail: any further beat is unexpected
    stall_pct = 0;
    repeat (40) @(posedge clk);
    if (board.expected_verdicts.size() != 0)
      board.flag($sformatf("%0d results never arrived", board.expected_verdicts.size()));
    if (board.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: color_contrast_check.f
design/ccc_pkg.sv
design/ccc_ifs.sv
design/ccc_luma.sv
design/ccc_div.sv
design/ccc_judge.sv
design/color_contrast_check.sv
design/ccc_check.sv
bench/tb_top.sv
